### rtl/kbd_scan_pkg.sv
// Shared types, constants and the key map ROM for the keyboard matrix scanner.
// Used by kbd_scan_ctrl, kbd_scan_dp and keyboard_matrix_port_scanner.
package kbd_scan_pkg;

    // Matrix geometry
    localparam int NUM_ROWS  = 11;
    localparam int ROW_W     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int PAT_W     = 11;
    localparam int SCAN_ROWS = (NUM_ROWS < PAT_W) ? NUM_ROWS : PAT_W;
    localparam int PORT_A_ROWS = 8;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int CODE_W = 16;
    localparam int DA_W   = 8;
    localparam int DB_W   = 3;
    localparam int DATA_W = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    // Register reset value and count ceiling
    localparam logic [DATA_W-1:0] REPEAT_LIMIT_RESET = 8'd3;
    localparam logic [DATA_W-1:0] COUNT_MAX          = 8'hFF;

    // Host key codes
    localparam logic [CODE_W-1:0] KEY_ENTER   = 16'hFF0D;
    localparam logic [CODE_W-1:0] KEY_UP      = 16'hFF52;
    localparam logic [CODE_W-1:0] KEY_DOWN    = 16'hFF54;
    localparam logic [CODE_W-1:0] KEY_LEFT    = 16'hFF51;
    localparam logic [CODE_W-1:0] KEY_RIGHT   = 16'hFF53;
    localparam logic [CODE_W-1:0] KEY_SHIFT_L = 16'hFFE1;
    localparam logic [CODE_W-1:0] KEY_SHIFT_R = 16'hFFE2;
    localparam logic [CODE_W-1:0] KEY_TBL_LO  = 16'h0020;
    localparam logic [CODE_W-1:0] KEY_TBL_HI  = 16'h00AF;

    // Result of a key map lookup
    typedef struct packed {
        logic       mapped;
        logic [3:0] row;
        logic [7:0] mask;
    } key_map_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    // Key map ROM: fixed special keys plus the 0x20..0xAF table
    function automatic key_map_t key_lookup(input logic [CODE_W-1:0] code);
        key_map_t k;
        k.mapped = 1'b1;
        k.row    = 4'd0;
        k.mask   = 8'h00;
        unique case (code)
            KEY_ENTER:   begin k.row = 4'd5;  k.mask = 8'h80; end
            KEY_UP:      begin k.row = 4'd0;  k.mask = 8'h10; end
            KEY_DOWN:    begin k.row = 4'd8;  k.mask = 8'h10; end
            KEY_LEFT:    begin k.row = 4'd1;  k.mask = 8'h10; end
            KEY_RIGHT:   begin k.row = 4'd2;  k.mask = 8'h10; end
            KEY_SHIFT_L,
            KEY_SHIFT_R: begin k.row = 4'd9;  k.mask = 8'h10; end
            16'h0020:    begin k.row = 4'd4;  k.mask = 8'h80; end
            16'h0030:    begin k.row = 4'd6;  k.mask = 8'h80; end
            16'h0031:    begin k.row = 4'd0;  k.mask = 8'h02; end
            16'h0032:    begin k.row = 4'd10; k.mask = 8'h04; end
            16'h0033:    begin k.row = 4'd9;  k.mask = 8'h04; end
            16'h0034:    begin k.row = 4'd0;  k.mask = 8'h08; end
            16'h0035:    begin k.row = 4'd10; k.mask = 8'h08; end
            16'h0036:    begin k.row = 4'd9;  k.mask = 8'h08; end
            16'h0037:    begin k.row = 4'd0;  k.mask = 8'h02; end
            16'h0038:    begin k.row = 4'd10; k.mask = 8'h02; end
            16'h0039:    begin k.row = 4'd9;  k.mask = 8'h02; end
            16'h0061:    begin k.row = 4'd10; k.mask = 8'h40; end
            16'h0062:    begin k.row = 4'd1;  k.mask = 8'h80; end
            16'h0063:    begin k.row = 4'd8;  k.mask = 8'h80; end
            16'h0064:    begin k.row = 4'd8;  k.mask = 8'h40; end
            16'h0065:    begin k.row = 4'd8;  k.mask = 8'h20; end
            16'h0066:    begin k.row = 4'd0;  k.mask = 8'h40; end
            16'h0067:    begin k.row = 4'd1;  k.mask = 8'h40; end
            16'h0068:    begin k.row = 4'd2;  k.mask = 8'h40; end
            16'h0069:    begin k.row = 4'd4;  k.mask = 8'h20; end
            16'h006A:    begin k.row = 4'd3;  k.mask = 8'h40; end
            16'h006B:    begin k.row = 4'd4;  k.mask = 8'h40; end
            16'h006C:    begin k.row = 4'd5;  k.mask = 8'h40; end
            16'h006D:    begin k.row = 4'd3;  k.mask = 8'h80; end
            16'h006E:    begin k.row = 4'd2;  k.mask = 8'h80; end
            16'h006F:    begin k.row = 4'd2;  k.mask = 8'h08; end
            16'h0070:    begin k.row = 4'd1;  k.mask = 8'h08; end
            16'h0071:    begin k.row = 4'd10; k.mask = 8'h20; end
            16'h0072:    begin k.row = 4'd0;  k.mask = 8'h20; end
            16'h0073:    begin k.row = 4'd9;  k.mask = 8'h40; end
            16'h0074:    begin k.row = 4'd1;  k.mask = 8'h20; end
            16'h0075:    begin k.row = 4'd3;  k.mask = 8'h20; end
            16'h0076:    begin k.row = 4'd0;  k.mask = 8'h80; end
            16'h0077:    begin k.row = 4'd9;  k.mask = 8'h20; end
            16'h0078:    begin k.row = 4'd9;  k.mask = 8'h80; end
            16'h0079:    begin k.row = 4'd2;  k.mask = 8'h20; end
            16'h007A:    begin k.row = 4'd10; k.mask = 8'h80; end
            16'h00AC:    begin k.row = 4'd8;  k.mask = 8'h10; end
            16'h00AD:    begin k.row = 4'd2;  k.mask = 8'h10; end
            16'h00AE:    begin k.row = 4'd0;  k.mask = 8'h10; end
            16'h00AF:    begin k.row = 4'd1;  k.mask = 8'h10; end
            default:
            begin
                // empty table slots map to nothing; outside the table is unmapped
                if (code < KEY_TBL_LO || code > KEY_TBL_HI)
                begin
                    k.mapped = 1'b0;
                end
            end
        endcase
        return k;
    endfunction

endpackage

### rtl/keyboard_matrix_port_scanner.sv
// Top level of the keyboard matrix scanner: joins controller and datapath.
// Depends on kbd_scan_pkg, kbd_scan_ctrl and kbd_scan_dp.
//
// Usage:
//   Command channel: an item (command, key_code, drive_a, drive_b) is taken
//   at a rising edge with start high and busy low. Press and release set or
//   clear one bit of the key matrix image through the key map ROM; a read
//   returns the lowest driven row, gated by the repeat tracker.
//   Result channel: done is high for exactly one cycle with read_data and
//   key_ignored valid in that cycle. The receiver cannot stall the block.
//   An item taken in ST_IDLE executes in ST_EXEC, and done is registered as
//   it leaves ST_EXEC. busy is high for the single execute cycle, in which
//   the key map lookup, the row select and the tracker update are done.
//   A new item may start in the same cycle done is shown; none while busy.
//   Configuration: repeat_limit is written through cfg_valid/cfg_ready/
//   cfg_data; cfg_ready is high whenever the block is not busy.
//   Reset: rst_n clears the matrix image and the repeat tracker, sets
//   repeat_limit to 3 and leaves the block idle with done low.
module keyboard_matrix_port_scanner (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [kbd_scan_pkg::CMD_W-1:0]      command,
    input  logic [kbd_scan_pkg::CODE_W-1:0]     key_code,
    input  logic [kbd_scan_pkg::DA_W-1:0]       drive_a,
    input  logic [kbd_scan_pkg::DB_W-1:0]       drive_b,
    output logic                                done,
    output logic [kbd_scan_pkg::DATA_W-1:0]     read_data,
    output logic                                key_ignored,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kbd_scan_pkg::DATA_W-1:0]     cfg_data
);

    kbd_scan_pkg::ctrl_cmd_t ctrl_cmd;
    logic                    busy_int;
    logic                    cfg_write;

    // Accept configuration writes while not executing
    assign cfg_ready = ~busy_int;
    assign cfg_write = cfg_valid & ~busy_int;
    assign busy      = busy_int;

    kbd_scan_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy_int),
        .done  (done),
        .cmd   (ctrl_cmd)
    );

    kbd_scan_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctrl_cmd),
        .command     (command),
        .key_code    (key_code),
        .drive_a     (drive_a),
        .drive_b     (drive_b),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .read_data   (read_data),
        .key_ignored (key_ignored)
    );

endmodule

### rtl/kbd_scan_ctrl.sv
// Controller for the keyboard matrix scanner: accept, execute, signal done.
// Depends on kbd_scan_pkg.
module kbd_scan_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    output logic                    done,
    output kbd_scan_pkg::ctrl_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Decode commands to the datapath
    always_comb
    begin
        cmd.capture = (state_reg == ST_IDLE) && start;
        cmd.execute = (state_reg == ST_EXEC);
    end

    // Next state: each accepted item goes through ST_EXEC, then back to idle
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

### rtl/kbd_scan_dp.sv
// Datapath for the keyboard matrix scanner: matrix image, repeat tracker,
// key map lookup, row select and result registers. Depends on kbd_scan_pkg.
module kbd_scan_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  kbd_scan_pkg::ctrl_cmd_t                 cmd,
    input  logic [kbd_scan_pkg::CMD_W-1:0]          command,
    input  logic [kbd_scan_pkg::CODE_W-1:0]         key_code,
    input  logic [kbd_scan_pkg::DA_W-1:0]           drive_a,
    input  logic [kbd_scan_pkg::DB_W-1:0]           drive_b,
    input  logic                                    cfg_write,
    input  logic [kbd_scan_pkg::DATA_W-1:0]         cfg_data,
    output logic [kbd_scan_pkg::DATA_W-1:0]         read_data,
    output logic                                    key_ignored
);

    // Captured item
    logic [kbd_scan_pkg::CMD_W-1:0]  cmd_reg;
    logic [kbd_scan_pkg::CODE_W-1:0] code_reg;
    logic [kbd_scan_pkg::DA_W-1:0]   da_reg;
    logic [kbd_scan_pkg::DB_W-1:0]   db_reg;

    // Block state
    logic [kbd_scan_pkg::DATA_W-1:0] matrix_reg [kbd_scan_pkg::NUM_ROWS];
    logic [kbd_scan_pkg::DATA_W-1:0] matrix_next [kbd_scan_pkg::NUM_ROWS];
    logic [kbd_scan_pkg::PAT_W-1:0]  last_pat_reg, last_pat_next;
    logic [kbd_scan_pkg::DATA_W-1:0] last_bits_reg, last_bits_next;
    logic [kbd_scan_pkg::DATA_W-1:0] count_reg, count_next;
    logic [kbd_scan_pkg::DATA_W-1:0] limit_reg;
    logic [kbd_scan_pkg::DATA_W-1:0] read_data_reg, read_data_next;
    logic                            key_ignored_reg, key_ignored_next;

    // Working signals
    kbd_scan_pkg::key_map_t          lk;
    logic                            row_ok;
    logic [kbd_scan_pkg::PAT_W-1:0]  pattern;
    logic                            found;
    logic [kbd_scan_pkg::ROW_W-1:0]  sel;
    logic [kbd_scan_pkg::DATA_W-1:0] bits;
    logic [kbd_scan_pkg::DATA_W-1:0] base_count;
    logic [kbd_scan_pkg::DATA_W-1:0] new_count;
    logic [kbd_scan_pkg::DATA_W-1:0] val;

    // Look up the key and find the lowest driven row
    always_comb
    begin
        lk      = kbd_scan_pkg::key_lookup(code_reg);
        row_ok  = ({1'b0, lk.row} < 5'(kbd_scan_pkg::NUM_ROWS));
        pattern = {db_reg, da_reg};
        found   = 1'b0;
        sel     = '0;
        for (int i = kbd_scan_pkg::SCAN_ROWS - 1; i >= 0; i--)
        begin
            if (pattern[i])
            begin
                found = 1'b1;
                sel   = kbd_scan_pkg::ROW_W'(i);
            end
        end
        bits = matrix_reg[sel];
    end

    // Work out the repeat count and the value read
    always_comb
    begin
        if (last_pat_reg != pattern || last_bits_reg != bits)
        begin
            base_count = '0;
        end
        else
        begin
            base_count = count_reg;
        end
        if (bits != '0)
        begin
            new_count = (base_count < kbd_scan_pkg::COUNT_MAX) ?
                        base_count + 8'd1 : base_count;
        end
        else
        begin
            new_count = count_reg;
        end
        val = (new_count < limit_reg) ? bits : '0;
        if ({1'b0, sel} < 5'(kbd_scan_pkg::PORT_A_ROWS))
        begin
            val = val | da_reg;
        end
    end

    // Apply the item to state and form the result
    always_comb
    begin
        for (int i = 0; i < kbd_scan_pkg::NUM_ROWS; i++)
        begin
            matrix_next[i] = matrix_reg[i];
        end
        last_pat_next    = last_pat_reg;
        last_bits_next   = last_bits_reg;
        count_next       = count_reg;
        read_data_next   = '0;
        key_ignored_next = 1'b0;

        if (cmd_reg == kbd_scan_pkg::CMD_PRESS || cmd_reg == kbd_scan_pkg::CMD_RELEASE)
        begin
            if (cmd_reg == kbd_scan_pkg::CMD_RELEASE)
            begin
                last_pat_next  = '0;
                last_bits_next = '0;
                count_next     = '0;
            end
            if (!lk.mapped)
            begin
                key_ignored_next = 1'b1;
            end
            else if (row_ok)
            begin
                if (cmd_reg == kbd_scan_pkg::CMD_PRESS)
                begin
                    matrix_next[lk.row[kbd_scan_pkg::ROW_W-1:0]] =
                        matrix_reg[lk.row[kbd_scan_pkg::ROW_W-1:0]] | lk.mask;
                end
                else
                begin
                    matrix_next[lk.row[kbd_scan_pkg::ROW_W-1:0]] =
                        matrix_reg[lk.row[kbd_scan_pkg::ROW_W-1:0]] & ~lk.mask;
                end
            end
        end
        else if (cmd_reg == kbd_scan_pkg::CMD_READ)
        begin
            if (found)
            begin
                read_data_next = val;
                count_next     = new_count;
                if (bits != '0)
                begin
                    last_pat_next  = pattern;
                    last_bits_next = bits;
                end
            end
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= command;
            code_reg <= key_code;
            da_reg   <= drive_a;
            db_reg   <= drive_b;
        end
    end

    // Update state and results on execute; take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kbd_scan_pkg::NUM_ROWS; i++)
            begin
                matrix_reg[i] <= '0;
            end
            last_pat_reg    <= '0;
            last_bits_reg   <= '0;
            count_reg       <= '0;
            limit_reg       <= kbd_scan_pkg::REPEAT_LIMIT_RESET;
            read_data_reg   <= '0;
            key_ignored_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.execute)
            begin
                for (int i = 0; i < kbd_scan_pkg::NUM_ROWS; i++)
                begin
                    matrix_reg[i] <= matrix_next[i];
                end
                last_pat_reg    <= last_pat_next;
                last_bits_reg   <= last_bits_next;
                count_reg       <= count_next;
                read_data_reg   <= read_data_next;
                key_ignored_reg <= key_ignored_next;
            end
        end
    end

    assign read_data   = read_data_reg;
    assign key_ignored = key_ignored_reg;

endmodule
